// ----- sv/ctcgd_pkg.sv -----
// shared types and constants of the greedy ctc decoder
package ctcgd_pkg;

  localparam int SCORE_W    = 16;
  localparam int CHAR_IDX_W = 13;
  localparam int KEPT_W     = 10;
  localparam int CONF_W     = 16;
  localparam int CFG_W      = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUOT_STEPS = 16;
  localparam int STEP_W     = 4;

  localparam logic [CFG_W-1:0] CLASS_COUNT_RST = 14'd8192;
  localparam logic [CFG_W-1:0] DICT_SIZE_RST   = 14'd8192;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLASS_COUNT = 1'b0,
    CFG_DICT_SIZE   = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_e;

  // one finished row as seen by the back end
  typedef struct packed {
    logic                  keep;
    logic                  fin;
    logic [CHAR_IDX_W-1:0] char_idx;
    logic [SCORE_W-1:0]    score;
  } row_evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- sv/ctcgd_if.sv -----
// handshake channels of the greedy ctc decoder
interface ctcgd_score_if import ctcgd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic               last_step;

  modport source (output valid, output score, output last_step, input ready);
  modport sink (input valid, input score, input last_step, output ready);
endinterface

interface ctcgd_result_if import ctcgd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [CHAR_IDX_W-1:0] char_index;
  logic [SCORE_W-1:0]    char_score;
  logic [KEPT_W-1:0]     kept_count;
  logic [CONF_W-1:0]     confidence;
  logic                  last;

  modport source (output valid, output kind, output char_index, output char_score,
                  output kept_count, output confidence, output last, input ready);
  modport sink (input valid, input kind, input char_index, input char_score,
                input kept_count, input confidence, input last, output ready);
endinterface

interface ctcgd_cfg_if import ctcgd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/ctc_greedy_decoder.sv -----
// top level of the greedy ctc best-path decoder
// throughput: one score beat per cycle while the row queue has room
// a kept character passes through the row queue and the output register; the summary
// follows the final score once the serial mean divider has finished
// reset: async active low, clears sequence state, queue and output; registers to 8192
module ctc_greedy_decoder import ctcgd_pkg::*; #(
  parameter int MAX_CLASSES = 8192,
  parameter int MAX_STEPS   = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ctcgd_cfg_if.sink      cfg_i,
  ctcgd_score_if.sink    in_i,
  ctcgd_result_if.source out_o
);

  logic [CFG_W-1:0] class_count_q, class_count_d;
  logic [CFG_W-1:0] dict_size_q, dict_size_d;

  logic       push;
  logic       pop;
  row_evt_t   push_evt;
  row_evt_t   head_evt;
  fifo_stat_t fifo_stat;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    class_count_d = class_count_q;
    dict_size_d   = dict_size_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_CLASS_COUNT: class_count_d = cfg_i.data;
        CFG_DICT_SIZE:   dict_size_d   = cfg_i.data;
        default: begin
          class_count_d = class_count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= CLASS_COUNT_RST;
      dict_size_q   <= DICT_SIZE_RST;
    end else begin
      class_count_q <= class_count_d;
      dict_size_q   <= dict_size_d;
    end
  end

  ctcgd_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .class_count_i (class_count_q),
    .dict_size_i   (dict_size_q),
    .in_if         (in_i),
    .stat_i        (fifo_stat),
    .push_o        (push),
    .evt_o         (push_evt)
  );

  ctcgd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .evt_i  (push_evt),
    .pop_i  (pop),
    .evt_o  (head_evt),
    .stat_o (fifo_stat)
  );

  ctcgd_back #(
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (head_evt),
    .stat_i (fifo_stat),
    .pop_o  (pop),
    .out_if (out_o)
  );

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fifo_stat.full))
    else $error("row pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("row popped from empty queue");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.kind == out_o.last))
    else $error("summary and last flag disagree");

  a_summary_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind) |-> (out_o.char_index == '0 && out_o.char_score == '0))
    else $error("summary carries character fields");
`endif

endmodule

// ----- sv/ctcgd_front.sv -----
// row scanner: running argmax per row and keep/drop classification
module ctcgd_front import ctcgd_pkg::*; #(
  parameter int MAX_CLASSES = 8192
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] class_count_i,
  input  logic [CFG_W-1:0] dict_size_i,
  ctcgd_score_if.sink      in_if,
  input  fifo_stat_t       stat_i,
  output logic             push_o,
  output row_evt_t         evt_o
);

  localparam int PW = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
  localparam int CW = ((PW > CFG_W) ? PW : CFG_W) + 1;

  logic [PW-1:0]      pos_q, pos_d;
  logic [SCORE_W-1:0] top_score_q, top_score_d;
  logic [PW-1:0]      best_idx_q, best_idx_d;
  logic [PW-1:0]      prev_idx_q, prev_idx_d;
  logic               have_prev_q, have_prev_d;

  logic [CW-1:0]            cc_ext;
  logic [CW-1:0]            row_len;
  logic [CW-1:0]            pos_next;
  logic                     row_end;
  logic                     accept;
  logic                     take;
  logic [SCORE_W-1:0]       cur_score;
  logic [PW-1:0]            cur_idx;
  logic                     keep;
  logic [PW+CHAR_IDX_W-1:0] idx_wide;

  assign in_if.ready = !stat_i.full;
  assign accept      = in_if.valid && in_if.ready;

  assign cc_ext = CW'(class_count_i);

  always_comb begin
    priority if (cc_ext == '0) begin
      row_len = CW'(1);
    end else if (cc_ext > CW'(MAX_CLASSES)) begin
      row_len = CW'(MAX_CLASSES);
    end else begin
      row_len = cc_ext;
    end
  end

  assign pos_next = CW'(pos_q) + CW'(1);
  assign row_end  = !(pos_next < row_len);

  assign take      = (pos_q == '0) || (in_if.score > top_score_q);
  assign cur_score = take ? in_if.score : top_score_q;
  assign cur_idx   = take ? pos_q : best_idx_q;

  assign keep = (cur_idx != '0) && !(have_prev_q && (cur_idx == prev_idx_q))
                && (CW'(cur_idx) < CW'(dict_size_i));

  assign idx_wide = {CHAR_IDX_W'(0), cur_idx};

  assign push_o         = accept && row_end;
  assign evt_o.keep     = keep;
  assign evt_o.fin      = in_if.last_step;
  assign evt_o.char_idx = idx_wide[CHAR_IDX_W-1:0];
  assign evt_o.score    = cur_score;

  always_comb begin
    pos_d       = pos_q;
    top_score_d = top_score_q;
    best_idx_d  = best_idx_q;
    prev_idx_d  = prev_idx_q;
    have_prev_d = have_prev_q;
    if (accept) begin
      top_score_d = cur_score;
      best_idx_d  = cur_idx;
      if (row_end) begin
        pos_d       = '0;
        prev_idx_d  = cur_idx;
        have_prev_d = 1'b1;
        if (in_if.last_step) begin
          prev_idx_d  = '0;
          have_prev_d = 1'b0;
        end
      end else begin
        pos_d = pos_next[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      prev_idx_q  <= '0;
      have_prev_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      prev_idx_q  <= prev_idx_d;
      have_prev_q <= have_prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_score_q <= top_score_d;
    best_idx_q  <= best_idx_d;
  end

endmodule

// ----- sv/ctcgd_fifo.sv -----
// short queue of finished rows between scanner and emitter
module ctcgd_fifo import ctcgd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  row_evt_t   evt_i,
  input  logic       pop_i,
  output row_evt_t   evt_o,
  output fifo_stat_t stat_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  row_evt_t        mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign stat_o.full  = (cnt_q == NW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign evt_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= evt_i;
    end
  end

endmodule

// ----- sv/ctcgd_back.sv -----
// emitter: kept characters, score accumulation, serial mean and summary
module ctcgd_back import ctcgd_pkg::*; #(
  parameter int MAX_STEPS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  row_evt_t    evt_i,
  input  fifo_stat_t  stat_i,
  output logic        pop_o,
  ctcgd_result_if.source out_if
);

  localparam int TW = $clog2(MAX_STEPS + 1);
  localparam int SW = SCORE_W + TW;

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_DIV = 3'b010,
    ST_SUM = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;

  logic [SW-1:0]     sum_q, sum_d;
  logic [TW-1:0]     total_q, total_d;
  logic [TW-1:0]     rem_q, rem_d;
  logic [SCORE_W-1:0] sh_q, sh_d;
  logic [CONF_W-1:0] quot_q, quot_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  logic                  out_valid_q, out_valid_d;
  logic                  kind_q, kind_d;
  logic [CHAR_IDX_W-1:0] char_index_q, char_index_d;
  logic [SCORE_W-1:0]    char_score_q, char_score_d;
  logic [KEPT_W-1:0]     kept_count_q, kept_count_d;
  logic [CONF_W-1:0]     confidence_q, confidence_d;
  logic                  last_q, last_d;

  logic              slot_free;
  logic              acc;
  logic [SW-1:0]     sum_n;
  logic [TW-1:0]     total_n;
  logic [TW:0]       trial;
  logic              ge;
  logic [TW:0]       diff;
  logic [TW+KEPT_W-1:0] kept_wide;

  assign slot_free = !out_valid_q || out_if.ready;
  assign pop_o     = (state_q == ST_RUN) && !stat_i.empty && slot_free;

  assign acc     = evt_i.keep && (total_q < TW'(MAX_STEPS));
  assign sum_n   = acc ? sum_q + SW'(evt_i.score) : sum_q;
  assign total_n = acc ? total_q + TW'(1) : total_q;

  // one quotient bit per cycle
  assign trial = {rem_q, sh_q[SCORE_W-1]};
  assign ge    = (trial >= {1'b0, total_q});
  assign diff  = trial - {1'b0, total_q};

  assign kept_wide = {KEPT_W'(0), total_q};

  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    total_d      = total_q;
    rem_d        = rem_q;
    sh_d         = sh_q;
    quot_d       = quot_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    kind_d       = kind_q;
    char_index_d = char_index_q;
    char_score_d = char_score_q;
    kept_count_d = kept_count_q;
    confidence_d = confidence_q;
    last_d       = last_q;
    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_RUN: begin
        if (pop_o) begin
          sum_d   = sum_n;
          total_d = total_n;
          if (evt_i.keep) begin
            out_valid_d  = 1'b1;
            kind_d       = KIND_CHAR;
            char_index_d = evt_i.char_idx;
            char_score_d = evt_i.score;
            kept_count_d = '0;
            confidence_d = '0;
            last_d       = 1'b0;
          end
          if (evt_i.fin) begin
            rem_d   = sum_n[SW-1:SCORE_W];
            sh_d    = sum_n[SCORE_W-1:0];
            quot_d  = '0;
            cnt_d   = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d  = ge ? diff[TW-1:0] : trial[TW-1:0];
        sh_d   = {sh_q[SCORE_W-2:0], 1'b0};
        quot_d = {quot_q[CONF_W-2:0], ge};
        cnt_d  = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(QUOT_STEPS - 1)) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          kind_d       = KIND_SUMMARY;
          char_index_d = '0;
          char_score_d = '0;
          kept_count_d = kept_wide[KEPT_W-1:0];
          confidence_d = (total_q == '0) ? '0 : quot_q;
          last_d       = 1'b1;
          sum_d        = '0;
          total_d      = '0;
          state_d      = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      sum_q       <= '0;
      total_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      total_q     <= total_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    sh_q         <= sh_d;
    quot_q       <= quot_d;
    kind_q       <= kind_d;
    char_index_q <= char_index_d;
    char_score_q <= char_score_d;
    kept_count_q <= kept_count_d;
    confidence_q <= confidence_d;
    last_q       <= last_d;
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.kind       = kind_q;
  assign out_if.char_index = char_index_q;
  assign out_if.char_score = char_score_q;
  assign out_if.kept_count = kept_count_q;
  assign out_if.confidence = confidence_q;
  assign out_if.last       = last_q;

endmodule

// ----- tb/tb_ctc_greedy_decoder.sv -----
// testbench of the greedy ctc decoder: score rows streamed in, decoded tokens checked per beat
`timescale 1ns / 100ps

module tb_ctc_greedy_decoder;
  import ctcgd_pkg::*;

  localparam int MAX_CLASSES = 8192;
  localparam int MAX_STEPS = 512;
  localparam int CLK_PERIOD = 12;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_SCORES = 100;
  localparam int LIMIT_CYCLES = 1_000_000;

  typedef enum logic [1:0] {
    FEED_SCORE,
    FEED_WRITE,
    FEED_DRAIN
  } feed_op_e;

  typedef struct {
    feed_op_e           op;
    logic [SCORE_W-1:0] score;
    logic               last_step;
    cfg_reg_e           sel;
    logic [CFG_W-1:0]   data;
  } feed_t;

  typedef struct packed {
    result_kind_e          kind;
    logic [CHAR_IDX_W-1:0] char_index;
    logic [SCORE_W-1:0]    char_score;
    logic [KEPT_W-1:0]     kept_count;
    logic [CONF_W-1:0]     confidence;
    logic                  last;
  } decode_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ctcgd_cfg_if    cfg_bus();
  ctcgd_score_if  score_bus();
  ctcgd_result_if res_bus();

  ctc_greedy_decoder #(
    .MAX_CLASSES(MAX_CLASSES),
    .MAX_STEPS  (MAX_STEPS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (score_bus),
    .out_o (res_bus)
  );

  feed_t   stream_q[$];
  decode_t decoded_q[$];
  int      mismatch_count = 0;
  int      fed_scores = 0;

  int unsigned class_count_cfg = CLASS_COUNT_RST;
  int unsigned dict_size_cfg = DICT_SIZE_RST;
  int unsigned row_pos = 0;
  int unsigned lead_score = 0;
  int unsigned best_idx = 0;
  int unsigned prior_idx = 0;
  bit          prior_seen = 1'b0;
  int unsigned score_sum = 0;
  int unsigned kept_n = 0;

  int          burst_left = 1;
  int          gap_left = 0;
  int          settle_left = SETTLE_CYCLES;
  logic [15:0] stall_mask = '1;
  int          mask_age = 0;

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  task automatic set_register(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] data);
    if (sel == CFG_CLASS_COUNT) begin
      class_count_cfg = data;
    end else begin
      dict_size_cfg = data;
    end
  endtask

  task automatic decode_score(input logic [SCORE_W-1:0] s, input logic fin);
    int unsigned n;
    int unsigned mean;
    bit          keep;
    decode_t     r;
    n = class_count_cfg;
    if (n == 0) n = 1;
    if (n > MAX_CLASSES) n = MAX_CLASSES;
    if (row_pos == 0 || s > lead_score) begin
      lead_score = s;
      best_idx = row_pos;
    end
    if (row_pos + 1 < n) begin
      row_pos++;
    end else begin
      keep = best_idx != 0 && !(prior_seen && best_idx == prior_idx) && best_idx < dict_size_cfg;
      prior_idx = best_idx;
      prior_seen = 1'b1;
      row_pos = 0;
      if (keep) begin
        if (kept_n < MAX_STEPS) begin
          score_sum += lead_score;
          kept_n++;
        end
        r = '0;
        r.kind = KIND_CHAR;
        r.char_index = CHAR_IDX_W'(best_idx);
        r.char_score = SCORE_W'(lead_score);
        decoded_q = {decoded_q, r};
      end
      if (fin) begin
        mean = (kept_n != 0) ? score_sum / kept_n : 0;
        r = '0;
        r.kind = KIND_SUMMARY;
        r.kept_count = KEPT_W'(kept_n);
        r.confidence = CONF_W'(mean);
        r.last = 1'b1;
        decoded_q = {decoded_q, r};
        lead_score = 0;
        best_idx = 0;
        prior_idx = 0;
        prior_seen = 1'b0;
        score_sum = 0;
        kept_n = 0;
      end
    end
  endtask

  function automatic bit match_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic push_score(input int s, input bit fin);
    feed_t f;
    f.op = FEED_SCORE;
    f.score = SCORE_W'(s);
    f.last_step = fin;
    f.sel = CFG_CLASS_COUNT;
    f.data = '0;
    stream_q = {stream_q, f};
    fed_scores++;
  endtask

  task automatic push_write(input cfg_reg_e sel, input int unsigned data);
    feed_t f;
    f.op = FEED_WRITE;
    f.score = '0;
    f.last_step = 1'b0;
    f.sel = sel;
    f.data = CFG_W'(data);
    stream_q = {stream_q, f};
  endtask

  task automatic push_drain();
    feed_t f;
    f.op = FEED_DRAIN;
    f.score = '0;
    f.last_step = 1'b0;
    f.sel = CFG_CLASS_COUNT;
    f.data = '0;
    stream_q = {stream_q, f};
  endtask

  // winner strictly above earlier scores, ties allowed after it
  task automatic push_row(input int n, input int winner, input int ws, input bit fin);
    int s;
    bit stray;
    for (int i = 0; i < n; i++) begin
      if (i == winner) s = ws;
      else if (i < winner) s = $urandom_range(0, ws - 1);
      else s = $urandom_range(0, ws);
      stray = (i != n - 1) && ($urandom_range(0, 9) == 0);
      push_score(s, (i == n - 1) ? fin : stray);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    feed_t head;
    logic  send_score;
    logic  send_write;
    if (!rst_ni) begin
      score_bus.valid <= 1'b0;
      score_bus.score <= '0;
      score_bus.last_step <= 1'b0;
      cfg_bus.valid <= 1'b0;
      cfg_bus.index <= '0;
      cfg_bus.data <= '0;
    end else begin
      send_score = score_bus.valid;
      send_write = cfg_bus.valid;
      if (score_bus.valid && score_bus.ready) begin
        decode_score(score_bus.score, score_bus.last_step);
        void'(stream_q.pop_front());
        send_score = 1'b0;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        set_register(cfg_bus.index, cfg_bus.data);
        void'(stream_q.pop_front());
        send_write = 1'b0;
      end
      if (!send_score && !send_write && stream_q.size() != 0) begin
        head = stream_q[0];
        case (head.op)
          FEED_SCORE: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              send_score = 1'b1;
              score_bus.score <= head.score;
              score_bus.last_step <= head.last_step;
              if (burst_left > 1) begin
                burst_left--;
              end else begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                         : $urandom_range(1, 32);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
              end
            end
          end
          FEED_WRITE: begin
            send_write = 1'b1;
            cfg_bus.index <= head.sel;
            cfg_bus.data <= head.data;
          end
          FEED_DRAIN: begin
            if (decoded_q.size() != 0) begin
              settle_left = SETTLE_CYCLES;
            end else if (settle_left != 0) begin
              settle_left--;
            end else begin
              void'(stream_q.pop_front());
              settle_left = SETTLE_CYCLES;
            end
          end
          default: ;
        endcase
      end
      score_bus.valid <= send_score;
      cfg_bus.valid <= send_write;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    decode_t want;
    bit      ok;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result beat expected none actual kind %0d index %0d count %0d",
                   $time, res_bus.kind, res_bus.char_index, res_bus.kept_count);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          ok = match_field("kind", want.kind, res_bus.kind);
          ok &= match_field("char_index", want.char_index, res_bus.char_index);
          ok &= match_field("char_score", want.char_score, res_bus.char_score);
          ok &= match_field("kept_count", want.kept_count, res_bus.kept_count);
          ok &= match_field("confidence", want.confidence, res_bus.confidence);
          ok &= match_field("last", want.last, res_bus.last);
          if (!ok) mismatch_count++;
        end
      end
      if (mask_age == 0) begin
        mask_age = 64;
        case ($urandom_range(0, 3))
          0: stall_mask = '1;
          1: stall_mask = 16'($urandom);
          2: stall_mask = 16'($urandom) | 16'($urandom);
          default: stall_mask = 16'($urandom) & 16'($urandom);
        endcase
        stall_mask[$urandom_range(0, 15)] = 1'b1;
      end
      mask_age--;
      res_bus.ready <= stall_mask[0];
      stall_mask = {stall_mask[0], stall_mask[15:1]};
    end
  end

  initial begin
    int cc;
    int n;
    int dict;
    int prev;
    int winner;
    int ws;
    int rows;
    int random_start;
    rst_ni = 1'b0;
    score_bus.valid = 1'b0;
    score_bus.score = '0;
    score_bus.last_step = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    res_bus.ready = 1'b0;

    // blank, repeat, out of dictionary, stray last_step, kept
    push_write(CFG_CLASS_COUNT, 4);
    push_write(CFG_DICT_SIZE, 3);
    push_score(0, 0); push_score(0, 0); push_score(0, 0); push_score(0, 0);
    push_score(1, 0); push_score(5, 0); push_score(5, 0); push_score(2, 0);
    push_score(0, 0); push_score(9, 0); push_score(3, 0); push_score(3, 0);
    push_score(0, 0); push_score(1, 0); push_score(2, 0); push_score(7, 0);
    push_score(0, 0); push_score(0, 1); push_score(8, 0); push_score(0, 0);
    push_score(16'hFFFF, 0); push_score(16'hFFFF, 0); push_score(0, 0); push_score(1, 1);
    push_drain();
    push_write(CFG_CLASS_COUNT, 0);
    push_score(7, 0); push_score(16'hFFFF, 1);
    push_drain();
    push_write(CFG_CLASS_COUNT, 1);
    push_score(0, 1);
    push_drain();
    push_write(CFG_CLASS_COUNT, 2);
    push_write(CFG_DICT_SIZE, 0);
    push_score(0, 0); push_score(5, 1);
    push_drain();

    // shorten the row while one is half done
    push_write(CFG_CLASS_COUNT, 6);
    push_write(CFG_DICT_SIZE, 8192);
    push_score(0, 0); push_score(2, 0); push_score(9, 0); push_score(1, 0);
    push_drain();
    push_write(CFG_CLASS_COUNT, 3);
    push_score(3, 1);
    push_drain();

    // more kept characters than the count can hold
    push_write(CFG_DICT_SIZE, 3);
    for (int k = 0; k < 514; k++) begin
      push_row(3, (k % 2 == 0) ? 1 : 2,
               (k % 7 == 0) ? $urandom_range(1, 65535) : 16'hFFFF, k == 513);
    end
    push_drain();

    random_start = fed_scores;
    while (fed_scores < random_start + RANDOM_SCORES) begin
      case ($urandom_range(0, 15))
        0: cc = 0;
        1: cc = 1;
        2, 3: cc = $urandom_range(9, 40);
        default: cc = $urandom_range(2, 8);
      endcase
      n = (cc == 0) ? 1 : cc;
      case ($urandom_range(0, 5))
        0: dict = 8192;
        1: dict = 0;
        2: dict = 16383;
        3: dict = 1;
        default: dict = $urandom_range(0, n + 2);
      endcase
      push_write(CFG_CLASS_COUNT, cc);
      if ($urandom_range(0, 3) != 0) push_write(CFG_DICT_SIZE, dict);
      repeat ($urandom_range(1, 4)) begin
        rows = $urandom_range(1, 10);
        prev = 0;
        for (int r = 0; r < rows; r++) begin
          case ($urandom_range(0, 5))
            0: winner = prev;
            1: winner = 0;
            default: winner = $urandom_range(0, n - 1);
          endcase
          case ($urandom_range(0, 3))
            0: ws = 16'hFFFF;
            1: ws = $urandom_range(1, 3);
            default: ws = $urandom_range(1, 65535);
          endcase
          push_row(n, winner, ws, r == rows - 1);
          prev = winner;
        end
      end
      push_drain();
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stream_q.size() != 0 || score_bus.valid || cfg_bus.valid) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && decoded_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
